FILE: rtl/ipmbrc_pkg.sv
`timescale 1ns / 1ps

package ipmbrc_pkg;

  // frame limits and byte positions
  localparam int unsigned MaxFrameBytes = 255;
  localparam logic [7:0] MAX_FRAME_BYTES = 8'(MaxFrameBytes);
  localparam logic [7:0] MIN_FRAME       = 8'd6;
  localparam logic [7:0] MIN_WITH_CC     = 8'd8;
  localparam logic [7:0] HDR_BYTES       = 8'd3;
  localparam logic [7:0] SEQ_POS         = 8'd4;
  localparam logic [7:0] CC_POS          = 8'd6;

  // frame status codes
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_TOO_LONG  = 3'd2,
    STATUS_HDR_SUM   = 3'd3,
    STATUS_DATA_SUM  = 3'd4,
    STATUS_CC_ERROR  = 3'd5,
    STATUS_SEQ_MISS  = 3'd6
  } status_e;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  // one frame result
  typedef struct packed {
    logic [2:0] frame_status;
    logic       response_done;
    logic [5:0] seq_seen;
    logic [7:0] comp_code;
    logic [7:0] frame_length;
  } out_item_t;

  // frame totals handed to the status check
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] header_sum;
    logic [7:0] data_sum;
    logic [7:0] seq_byte;
    logic [7:0] cc_byte;
  } frame_sum_t;

endpackage

FILE: rtl/ipmbrc_status.sv
`timescale 1ns / 1ps

module ipmbrc_status (
  input  ipmbrc_pkg::frame_sum_t sum_i,
  input  logic [5:0]             expected_seq_i,
  output ipmbrc_pkg::out_item_t  result_o
);

  logic [5:0]          seq_seen;
  logic [7:0]          cc_out;
  ipmbrc_pkg::status_e status;

  // sequence field and completion code as reported
  assign seq_seen = sum_i.seq_byte[7:2];
  assign cc_out   = (sum_i.len >= ipmbrc_pkg::MIN_WITH_CC) ? sum_i.cc_byte : 8'd0;

  // first failing check sets the status
  always_comb begin
    priority if (sum_i.len < ipmbrc_pkg::MIN_FRAME) begin
      status = ipmbrc_pkg::STATUS_SHORT;
    end else if (sum_i.len >= ipmbrc_pkg::MAX_FRAME_BYTES) begin
      status = ipmbrc_pkg::STATUS_TOO_LONG;
    end else if (sum_i.header_sum != 8'd0) begin
      status = ipmbrc_pkg::STATUS_HDR_SUM;
    end else if (sum_i.data_sum != 8'd0) begin
      status = ipmbrc_pkg::STATUS_DATA_SUM;
    end else if ((sum_i.len < ipmbrc_pkg::MIN_WITH_CC) || (sum_i.cc_byte != 8'd0)) begin
      status = ipmbrc_pkg::STATUS_CC_ERROR;
    end else if (seq_seen != expected_seq_i) begin
      status = ipmbrc_pkg::STATUS_SEQ_MISS;
    end else begin
      status = ipmbrc_pkg::STATUS_OK;
    end
  end

  // pack the result
  always_comb begin
    result_o.frame_status  = status;
    result_o.response_done = (status == ipmbrc_pkg::STATUS_OK);
    result_o.seq_seen      = seq_seen;
    result_o.comp_code     = cc_out;
    result_o.frame_length  = sum_i.len;
  end

endmodule

FILE: rtl/ipmb_response_checker_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i  (rx_byte, last_byte)
// out       output     out_valid_o / out_ready_i out_data_o (status, done, seq, cc, len)
// cfg       input      cfg_we_i                  cfg_wdata_i (expected_seq)
//
// one byte is taken per cycle while in_ready_o is high; running sums and byte count update at the transfer
// a byte with last_byte set has its result in the output register in the cycle after its transfer
// in_ready_o is high while the output register is empty or being drained this cycle
// reset clears the frame state, the expected sequence and the output valid

module ipmb_response_checker_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [5:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ipmbrc_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ipmbrc_pkg::out_item_t out_data_o
);

  logic [5:0] expected_seq_q;
  logic [7:0] byte_count_q, byte_count_d;
  logic [7:0] header_sum_q, header_sum_d;
  logic [7:0] data_sum_q, data_sum_d;
  logic [7:0] seq_byte_q, seq_byte_d;
  logic [7:0] cc_byte_q, cc_byte_d;
  logic       out_valid_q;
  ipmbrc_pkg::out_item_t out_data_q;

  logic                   in_xfer;
  ipmbrc_pkg::frame_sum_t frame_sum;
  ipmbrc_pkg::out_item_t  result;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // running frame state including the current byte
  always_comb begin
    header_sum_d = header_sum_q;
    data_sum_d   = data_sum_q;
    seq_byte_d   = seq_byte_q;
    cc_byte_d    = cc_byte_q;
    byte_count_d = byte_count_q;
    if (byte_count_q < ipmbrc_pkg::HDR_BYTES) begin
      header_sum_d = header_sum_q + in_data_i.rx_byte;
    end else begin
      data_sum_d = data_sum_q + in_data_i.rx_byte;
    end
    if (byte_count_q == ipmbrc_pkg::SEQ_POS) begin
      seq_byte_d = in_data_i.rx_byte;
    end
    if (byte_count_q == ipmbrc_pkg::CC_POS) begin
      cc_byte_d = in_data_i.rx_byte;
    end
    if (byte_count_q < ipmbrc_pkg::MAX_FRAME_BYTES) begin
      byte_count_d = byte_count_q + 8'd1;
    end
  end

  assign frame_sum = '{
    len:        byte_count_d,
    header_sum: header_sum_d,
    data_sum:   data_sum_d,
    seq_byte:   seq_byte_d,
    cc_byte:    cc_byte_d
  };

  ipmbrc_status u_status (
    .sum_i          (frame_sum),
    .expected_seq_i (expected_seq_q),
    .result_o       (result)
  );

  // expected sequence register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_seq_q <= 6'd0;
    end else if (cfg_we_i) begin
      expected_seq_q <= cfg_wdata_i;
    end
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 8'd0;
      header_sum_q <= 8'd0;
      data_sum_q   <= 8'd0;
      seq_byte_q   <= 8'd0;
      cc_byte_q    <= 8'd0;
    end else if (in_xfer) begin
      if (in_data_i.last_byte) begin
        byte_count_q <= 8'd0;
        header_sum_q <= 8'd0;
        data_sum_q   <= 8'd0;
        seq_byte_q   <= 8'd0;
        cc_byte_q    <= 8'd0;
      end else begin
        byte_count_q <= byte_count_d;
        header_sum_q <= header_sum_d;
        data_sum_q   <= data_sum_d;
        seq_byte_q   <= seq_byte_d;
        cc_byte_q    <= cc_byte_d;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.last_byte) begin
      out_data_q <= result;
    end
  end

endmodule
